// File: hdl/ls_pkg.sv
// Shared constants, types and helpers for the lottery scheduler.
package ls_pkg;

  // Table geometry
  localparam int SLOT_COUNT  = 16;
  localparam int TICKET_BITS = 16;
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int TOTAL_BITS  = TICKET_BITS + SLOT_BITS;

  // Fixed item field widths
  localparam int FIELD_SLOT_BITS = 4;
  localparam int COUNT_BITS      = 16;
  localparam int DRAW_BITS       = 31;
  localparam int DRAW_IDX_BITS   = $clog2(DRAW_BITS);
  localparam int MASK_BITS       = 16;
  localparam int MOVED_BITS      = 16;

  typedef logic [SLOT_BITS-1:0]       slot_idx_t;
  typedef logic [TICKET_BITS-1:0]     ticket_t;
  typedef logic [TOTAL_BITS-1:0]      total_t;
  typedef logic [DRAW_IDX_BITS-1:0]   draw_idx_t;

  localparam ticket_t   TICKET_MAX = '1;
  localparam slot_idx_t LAST_SLOT  = slot_idx_t'(SLOT_COUNT - 1);
  localparam draw_idx_t DRAW_TOP   = draw_idx_t'(DRAW_BITS - 1);

  typedef enum logic [1:0] {
    OP_ASSIGN   = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_TRANSFER = 2'd2,
    OP_SCHEDULE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  // Result of one item, handed from the sequencer to the output register
  typedef struct packed {
    logic [1:0]                 status;
    logic [FIELD_SLOT_BITS-1:0] winner_slot;
    logic                       winner_valid;
    logic [MOVED_BITS-1:0]      moved_tickets;
  } res_t;

  // Remainder unit request and response
  typedef struct packed {
    logic                 start;
    logic [DRAW_BITS-1:0] dividend;
    total_t               divisor;
  } rem_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    total_t rem;
  } rem_rsp_t;

  function automatic logic slot_in_range(logic [FIELD_SLOT_BITS-1:0] s);
    return 32'(s) < 32'(SLOT_COUNT);
  endfunction

  function automatic slot_idx_t to_idx(logic [FIELD_SLOT_BITS-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_BITS-1:0];
  endfunction

  function automatic logic [FIELD_SLOT_BITS-1:0] to_field(slot_idx_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[FIELD_SLOT_BITS-1:0];
  endfunction

  // Clamp an assigned count to the ticket range
  function automatic ticket_t sat_count(logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    if (w > 32'(TICKET_MAX)) begin
      return TICKET_MAX;
    end
    return w[TICKET_BITS-1:0];
  endfunction

  function automatic logic [MOVED_BITS-1:0] to_moved(ticket_t t);
    logic [31:0] w;
    w = 32'(t);
    return w[MOVED_BITS-1:0];
  endfunction

endpackage

// File: hdl/ls_in_if.sv
// Input item channel of the lottery scheduler.
interface ls_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            opcode;
  logic [ls_pkg::FIELD_SLOT_BITS-1:0]    slot;
  logic [ls_pkg::FIELD_SLOT_BITS-1:0]    target_slot;
  logic [ls_pkg::COUNT_BITS-1:0]         ticket_count;
  logic [ls_pkg::DRAW_BITS-1:0]          draw_value;
  logic [ls_pkg::MASK_BITS-1:0]          blocked_mask;

  modport source (
    output valid, opcode, slot, target_slot, ticket_count, draw_value, blocked_mask,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, target_slot, ticket_count, draw_value, blocked_mask,
    output ready
  );
endinterface

// File: hdl/ls_out_if.sv
// Result item channel of the lottery scheduler.
interface ls_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic [ls_pkg::FIELD_SLOT_BITS-1:0]    winner_slot;
  logic                                  winner_valid;
  logic [ls_pkg::MOVED_BITS-1:0]         moved_tickets;

  modport source (
    output valid, status, winner_slot, winner_valid, moved_tickets,
    input  ready
  );
  modport sink (
    input  valid, status, winner_slot, winner_valid, moved_tickets,
    output ready
  );
endinterface

// File: hdl/ls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ls_rem.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
module ls_rem (
  input  logic             clk,
  input  logic             rst_n,
  input  ls_pkg::rem_req_t req,
  output ls_pkg::rem_rsp_t rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  ls_pkg::draw_idx_t            bit_r, bit_nxt;
  logic [ls_pkg::DRAW_BITS-1:0] dividend_r, dividend_nxt;
  ls_pkg::total_t               divisor_r, divisor_nxt;
  ls_pkg::total_t               rem_r, rem_nxt;
  logic [ls_pkg::TOTAL_BITS:0]  trial;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    bit_nxt      = bit_r;
    dividend_nxt = dividend_r;
    divisor_nxt  = divisor_r;
    rem_nxt      = rem_r;
    trial        = {rem_r, dividend_r[bit_r]};
    if (req.start) begin
      busy_nxt     = 1'b1;
      bit_nxt      = ls_pkg::DRAW_TOP;
      dividend_nxt = req.dividend;
      divisor_nxt  = req.divisor;
      rem_nxt      = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor_r}) begin
        trial = trial - {1'b0, divisor_r};
      end
      rem_nxt = trial[ls_pkg::TOTAL_BITS-1:0];
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r      <= bit_nxt;
    dividend_r <= dividend_nxt;
    divisor_r  <= divisor_nxt;
    rem_r      <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < divisor_r)
    else $error("remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("remainder unit did not start");

endmodule

// File: hdl/ls_ctrl.sv
// Sequencer: decodes items, walks the ticket table and runs the draw.
module ls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  ls_in_if.sink         in_ch,
  output logic          res_valid,
  input  logic          res_ready,
  output ls_pkg::res_t  res
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_EXEC      = 12'b0000_0000_0010,
    S_T_WRS     = 12'b0000_0000_0100,
    S_T_RDD     = 12'b0000_0000_1000,
    S_T_WRD     = 12'b0000_0001_0000,
    S_SUM       = 12'b0000_0010_0000,
    S_SUM_LAST  = 12'b0000_0100_0000,
    S_DIV       = 12'b0000_1000_0000,
    S_SCAN      = 12'b0001_0000_0000,
    S_SCAN_LAST = 12'b0010_0000_0000,
    S_SRCH      = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [1:0]                           op_r, op_nxt;
  logic [ls_pkg::FIELD_SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic [ls_pkg::FIELD_SLOT_BITS-1:0]   tgt_r, tgt_nxt;
  logic [ls_pkg::COUNT_BITS-1:0]        count_r, count_nxt;
  logic [ls_pkg::DRAW_BITS-1:0]         draw_r, draw_nxt;
  logic [ls_pkg::MASK_BITS-1:0]         mask_r, mask_nxt;
  logic [ls_pkg::SLOT_COUNT-1:0]        in_use_r, in_use_nxt;
  ls_pkg::slot_idx_t                    cnt_r, cnt_nxt;
  ls_pkg::slot_idx_t                    pick_r, pick_nxt;
  ls_pkg::slot_idx_t                    prev_r, prev_nxt;
  logic                                 pend_r, pend_nxt;
  ls_pkg::total_t                       total_r, total_nxt;
  ls_pkg::total_t                       run_r, run_nxt;
  ls_pkg::total_t                       rem_r, rem_nxt;
  ls_pkg::ticket_t                      amount_r, amount_nxt;
  ls_pkg::res_t                         res_r, res_nxt;

  logic                                 ram_we, ram_re;
  ls_pkg::slot_idx_t                    ram_waddr, ram_raddr;
  ls_pkg::ticket_t                      ram_wdata, ram_rdata;
  ls_pkg::rem_req_t                     rem_req;
  ls_pkg::rem_rsp_t                     rem_rsp;

  logic [ls_pkg::SLOT_COUNT-1:0]        runnable;
  ls_pkg::total_t                       add_val, acc_sum;
  logic                                 src_ok, tgt_ok;
  ls_pkg::slot_idx_t                    src_idx, tgt_idx;
  logic [31:0]                          have_w, count_w;
  ls_pkg::ticket_t                      amount;
  logic [ls_pkg::TICKET_BITS:0]         dst_sum;

  ls_ram #(
    .WIDTH (ls_pkg::TICKET_BITS),
    .DEPTH (ls_pkg::SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ls_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // Runnable: in use and not blocked; slots beyond the mask are never blocked
  for (genvar j = 0; j < ls_pkg::SLOT_COUNT; j++) begin : g_run
    if (j < ls_pkg::MASK_BITS) begin : g_masked
      assign runnable[j] = in_use_r[j] & ~mask_r[j % ls_pkg::MASK_BITS];
    end else begin : g_free
      assign runnable[j] = in_use_r[j];
    end
  end

  assign src_ok  = ls_pkg::slot_in_range(slot_r);
  assign tgt_ok  = ls_pkg::slot_in_range(tgt_r);
  assign src_idx = ls_pkg::to_idx(slot_r);
  assign tgt_idx = ls_pkg::to_idx(tgt_r);

  // Table data returned for the slot read last cycle, zero when not in use
  assign add_val = (pend_r && in_use_r[prev_r]) ? ls_pkg::total_t'(ram_rdata) : '0;

  // Transfer amount: no more than the source holds
  assign have_w  = 32'(ram_rdata);
  assign count_w = 32'(count_r);
  assign amount  = (count_w < have_w) ? count_w[ls_pkg::TICKET_BITS-1:0] : ram_rdata;
  assign dst_sum = {1'b0, ram_rdata} + {1'b0, amount_r};

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    slot_nxt   = slot_r;
    tgt_nxt    = tgt_r;
    count_nxt  = count_r;
    draw_nxt   = draw_r;
    mask_nxt   = mask_r;
    in_use_nxt = in_use_r;
    cnt_nxt    = cnt_r;
    pick_nxt   = pick_r;
    prev_nxt   = prev_r;
    pend_nxt   = 1'b0;
    total_nxt  = total_r;
    run_nxt    = run_r;
    rem_nxt    = rem_r;
    amount_nxt = amount_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_waddr  = src_idx;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cnt_r;
    rem_req    = '0;
    acc_sum    = '0;

    unique case (state_r)
      // Take the next item
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          slot_nxt  = in_ch.slot;
          tgt_nxt   = in_ch.target_slot;
          count_nxt = in_ch.ticket_count;
          draw_nxt  = in_ch.draw_value;
          mask_nxt  = in_ch.blocked_mask;
          state_nxt = S_EXEC;
        end
      end

      // Decode and start the operation
      S_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = ls_pkg::ST_OK;
        state_nxt      = S_DONE;
        case (op_r)
          ls_pkg::OP_ASSIGN: begin
            if (!src_ok) begin
              res_nxt.status = ls_pkg::ST_BAD_SLOT;
            end else begin
              ram_we              = 1'b1;
              ram_waddr           = src_idx;
              ram_wdata           = ls_pkg::sat_count(count_r);
              in_use_nxt[src_idx] = 1'b1;
            end
          end
          ls_pkg::OP_RELEASE: begin
            if (!src_ok) begin
              res_nxt.status = ls_pkg::ST_BAD_SLOT;
            end else begin
              in_use_nxt[src_idx] = 1'b0;
            end
          end
          ls_pkg::OP_TRANSFER: begin
            if (!src_ok || !tgt_ok || !in_use_r[src_idx] || !in_use_r[tgt_idx]) begin
              res_nxt.status = ls_pkg::ST_BAD_SLOT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = src_idx;
              state_nxt = S_T_WRS;
            end
          end
          default: begin
            cnt_nxt   = '0;
            total_nxt = '0;
            state_nxt = S_SUM;
          end
        endcase
      end

      // Debit the source
      S_T_WRS: begin
        amount_nxt = amount;
        ram_we     = 1'b1;
        ram_waddr  = src_idx;
        ram_wdata  = ram_rdata - amount;
        state_nxt  = S_T_RDD;
      end

      // Read the destination after the debit has landed
      S_T_RDD: begin
        ram_re    = 1'b1;
        ram_raddr = tgt_idx;
        state_nxt = S_T_WRD;
      end

      // Credit the destination, saturating
      S_T_WRD: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_idx;
        ram_wdata = dst_sum[ls_pkg::TICKET_BITS] ? ls_pkg::TICKET_MAX
                                                 : dst_sum[ls_pkg::TICKET_BITS-1:0];
        res_nxt.moved_tickets = ls_pkg::to_moved(amount_r);
        state_nxt = S_DONE;
      end

      // Sum tickets of slots in use, one read per cycle
      S_SUM: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_r;
        prev_nxt  = cnt_r;
        pend_nxt  = 1'b1;
        total_nxt = total_r + add_val;
        if (cnt_r == ls_pkg::LAST_SLOT) begin
          state_nxt = S_SUM_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Fold in the last slot and start the remainder
      S_SUM_LAST: begin
        acc_sum   = total_r + add_val;
        total_nxt = acc_sum;
        if (acc_sum == '0) begin
          res_nxt.status = ls_pkg::ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = draw_r;
          rem_req.divisor  = acc_sum;
          state_nxt        = S_DIV;
        end
      end

      // Wait for draw modulo total
      S_DIV: begin
        if (rem_rsp.done) begin
          rem_nxt   = rem_rsp.rem;
          cnt_nxt   = '0;
          run_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      // Running sum until it exceeds the remainder
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_r;
        prev_nxt  = cnt_r;
        pend_nxt  = 1'b1;
        acc_sum   = run_r + add_val;
        run_nxt   = acc_sum;
        if (pend_r && in_use_r[prev_r] && acc_sum > rem_r) begin
          pick_nxt  = prev_r;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SRCH;
        end else if (cnt_r == ls_pkg::LAST_SLOT) begin
          state_nxt = S_SCAN_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Last slot must hold the crossing point
      S_SCAN_LAST: begin
        pick_nxt  = prev_r;
        cnt_nxt   = '0;
        state_nxt = S_SRCH;
      end

      // Circular search for a runnable slot from the pick
      S_SRCH: begin
        if (runnable[pick_r]) begin
          res_nxt.winner_slot  = ls_pkg::to_field(pick_r);
          res_nxt.winner_valid = 1'b1;
          state_nxt            = S_DONE;
        end else if (cnt_r == ls_pkg::LAST_SLOT) begin
          res_nxt.status = ls_pkg::ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          pick_nxt = (pick_r == ls_pkg::LAST_SLOT) ? '0 : pick_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_use_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_use_r <= in_use_nxt;
      pend_r   <= pend_nxt;
    end
    op_r     <= op_nxt;
    slot_r   <= slot_nxt;
    tgt_r    <= tgt_nxt;
    count_r  <= count_nxt;
    draw_r   <= draw_nxt;
    mask_r   <= mask_nxt;
    cnt_r    <= cnt_nxt;
    pick_r   <= pick_nxt;
    prev_r   <= prev_nxt;
    total_r  <= total_nxt;
    run_r    <= run_nxt;
    rem_r    <= rem_nxt;
    amount_r <= amount_nxt;
    res_r    <= res_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_EXEC)
    else $error("accepted item not decoded");

  a_winner_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_r.winner_valid |->
      res_r.status == ls_pkg::ST_OK && op_r == ls_pkg::OP_SCHEDULE)
    else $error("winner reported outside a successful schedule");

  a_rem_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    rem_req.start |-> !rem_rsp.busy)
    else $error("remainder started while busy");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_EXEC || state_r == S_T_WRS || state_r == S_T_WRD)
    else $error("table written outside a write step");

endmodule

// File: hdl/lottery_scheduler_top.sv
// Top level of the lottery scheduler: sequencer, ticket table and output register.
//
// One item at a time. Assign and release complete in the decode step, and the
// result is then offered. Transfer reads the source, debits it, reads the
// destination and credits it through the table's one write and one read
// port, then offers the result. Schedule walks the ticket table through its
// one read port to sum it, reduces the draw in the remainder unit at one bit
// a cycle, walks the table again for the winner and searches circularly for
// a runnable slot. The result is offered, and held until the output register
// takes it, before the next item can be taken.
// A finished result sits in the output register, so the next item is taken
// while it waits to be read.
module lottery_scheduler_top (
  input  logic      clk,
  input  logic      rst_n,
  ls_in_if.sink     in_ch,
  ls_out_if.source  out_ch
);

  logic          res_valid;
  logic          res_ready;
  ls_pkg::res_t  res;
  logic          out_valid_r, out_valid_nxt;
  ls_pkg::res_t  out_res_r, out_res_nxt;

  ls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.winner_slot   = out_res_r.winner_slot;
  assign out_ch.winner_valid  = out_res_r.winner_valid;
  assign out_ch.moved_tickets = out_res_r.moved_tickets;

endmodule

// File: test/lottery_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the lottery scheduler: mirrors the ticket table and compares every result.
module lottery_result_checker (
  input  logic clk,
  input  logic rst_n,
  ls_in_if     in_mon,
  ls_out_if    out_mon,
  output int   mismatch_count,
  output int   outstanding
);
  import ls_pkg::*;

  typedef struct packed {
    status_t                    status;
    logic [FIELD_SLOT_BITS-1:0] winner_slot;
    logic                       winner_valid;
    logic [MOVED_BITS-1:0]      moved_tickets;
  } lottery_result_t;

  ticket_t         tickets_held [SLOT_COUNT];
  logic            slot_live    [SLOT_COUNT];
  lottery_result_t pending_results [$];
  lottery_result_t oldest;
  int unsigned     wipe_idx;
  int              new_errors;

  // Apply one operation to the mirrored table and work out its result
  function automatic lottery_result_t apply_ticket_op(
    opcode_t                    op,
    logic [FIELD_SLOT_BITS-1:0] src,
    logic [FIELD_SLOT_BITS-1:0] dst,
    logic [COUNT_BITS-1:0]      count,
    logic [DRAW_BITS-1:0]       draw,
    logic [MASK_BITS-1:0]       mask
  );
    lottery_result_t r;
    int unsigned     s, d, i, pick, probe;
    longint unsigned total, running, remainder, sum, have, amount;
    bit              hit, found;
    r = '0;
    r.status = ST_OK;
    s = int'(src);
    d = int'(dst);
    case (op)
      OP_ASSIGN: begin
        if (s >= SLOT_COUNT) begin
          r.status = ST_BAD_SLOT;
        end else begin
          tickets_held[s] = (longint'(count) > longint'(TICKET_MAX)) ? TICKET_MAX
                                                                     : ticket_t'(count);
          slot_live[s] = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (s >= SLOT_COUNT) begin
          r.status = ST_BAD_SLOT;
        end else begin
          tickets_held[s] = '0;
          slot_live[s] = 1'b0;
        end
      end
      OP_TRANSFER: begin
        if (s >= SLOT_COUNT || d >= SLOT_COUNT || !slot_live[s] || !slot_live[d]) begin
          r.status = ST_BAD_SLOT;
        end else begin
          // debit first, then credit: a self transfer ends where it began
          have   = tickets_held[s];
          amount = (longint'(count) < have) ? longint'(count) : have;
          tickets_held[s] = ticket_t'(have - amount);
          sum = longint'(tickets_held[d]) + amount;
          tickets_held[d] = (sum > longint'(TICKET_MAX)) ? TICKET_MAX : ticket_t'(sum);
          r.moved_tickets = MOVED_BITS'(amount);
        end
      end
      default: begin
        total = 0;
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (slot_live[i]) total += tickets_held[i];
        end
        if (total == 0) begin
          r.status = ST_NONE;
        end else begin
          // first live slot whose running sum passes the remainder
          remainder = longint'(draw) % total;
          running = 0;
          pick = 0;
          hit = 1'b0;
          for (i = 0; i < SLOT_COUNT; i++) begin
            if (slot_live[i] && !hit) begin
              running += tickets_held[i];
              if (running > remainder) begin
                pick = i;
                hit = 1'b1;
              end
            end
          end
          // circular search for a live, unblocked slot from the pick onwards
          found = 1'b0;
          for (i = 0; i < SLOT_COUNT; i++) begin
            probe = (pick + i) % SLOT_COUNT;
            if (!found && slot_live[probe] && !(probe < MASK_BITS && mask[probe])) begin
              found = 1'b1;
              r.winner_slot = FIELD_SLOT_BITS'(probe);
              r.winner_valid = 1'b1;
            end
          end
          if (!found) r.status = ST_NONE;
        end
      end
    endcase
    return r;
  endfunction

  // Compare results first, then record the item taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (wipe_idx = 0; wipe_idx < SLOT_COUNT; wipe_idx++) begin
        tickets_held[wipe_idx] = '0;
        slot_live[wipe_idx] = 1'b0;
      end
      pending_results.delete();
      mismatch_count <= 0;
      outstanding <= 0;
    end else begin
      new_errors = 0;
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result item status=%0d winner=%0d valid=%0b moved=%0d",
                   $time, out_mon.status, out_mon.winner_slot, out_mon.winner_valid,
                   out_mon.moved_tickets);
          new_errors++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_mon.status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status,
                     out_mon.status);
            new_errors++;
          end
          if (out_mon.winner_slot !== oldest.winner_slot) begin
            $display("%0t: winner_slot expected %0d actual %0d", $time, oldest.winner_slot,
                     out_mon.winner_slot);
            new_errors++;
          end
          if (out_mon.winner_valid !== oldest.winner_valid) begin
            $display("%0t: winner_valid expected %0b actual %0b", $time,
                     oldest.winner_valid, out_mon.winner_valid);
            new_errors++;
          end
          if (out_mon.moved_tickets !== oldest.moved_tickets) begin
            $display("%0t: moved_tickets expected %0d actual %0d", $time,
                     oldest.moved_tickets, out_mon.moved_tickets);
            new_errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_ticket_op(opcode_t'(in_mon.opcode), in_mon.slot,
                                                  in_mon.target_slot, in_mon.ticket_count,
                                                  in_mon.draw_value, in_mon.blocked_mask));
      end
      mismatch_count <= mismatch_count + new_errors;
      outstanding <= pending_results.size();
    end
  end

endmodule

// File: test/lottery_scheduler_top_test.sv
`timescale 1ns / 100ps
// Testbench top: drives ticket operations into the lottery scheduler and reports the verdict.
module lottery_scheduler_top_test;
  import ls_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int RANDOM_ITEMS    = 650;
  localparam int SETTLE_CYCLES   = 120;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_PHASE  = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   outstanding;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic shadow_live [SLOT_COUNT];

  ls_in_if  in_ch ();
  ls_out_if out_ch ();

  lottery_scheduler_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lottery_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Offer one item, pausing between bursts, and hold it until taken
  task automatic offer_item(
    opcode_t                    op,
    logic [FIELD_SLOT_BITS-1:0] src,
    logic [FIELD_SLOT_BITS-1:0] dst,
    logic [COUNT_BITS-1:0]      count,
    logic [DRAW_BITS-1:0]       draw,
    logic [MASK_BITS-1:0]       mask
  );
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.slot         <= src;
    in_ch.target_slot  <= dst;
    in_ch.ticket_count <= count;
    in_ch.draw_value   <= draw;
    in_ch.blocked_mask <= mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (op == OP_ASSIGN) shadow_live[src] = 1'b1;
    if (op == OP_RELEASE) shadow_live[src] = 1'b0;
  endtask

  // Any slot believed to be in use, else any slot at all
  function automatic logic [FIELD_SLOT_BITS-1:0] random_live_slot();
    int unsigned start, k;
    start = $urandom_range(0, SLOT_COUNT - 1);
    for (k = 0; k < SLOT_COUNT; k++) begin
      if (shadow_live[(start + k) % SLOT_COUNT]) return FIELD_SLOT_BITS'((start + k) % SLOT_COUNT);
    end
    return FIELD_SLOT_BITS'(start);
  endfunction

  task automatic offer_random_item();
    opcode_t                    op;
    logic [FIELD_SLOT_BITS-1:0] src, dst;
    logic [COUNT_BITS-1:0]      count;
    logic [DRAW_BITS-1:0]       draw;
    logic [MASK_BITS-1:0]       mask;
    int                         roll;
    roll = $urandom_range(0, 99);
    if (roll < 28) op = OP_ASSIGN;
    else if (roll < 38) op = OP_RELEASE;
    else if (roll < 65) op = OP_TRANSFER;
    else op = OP_SCHEDULE;
    src = FIELD_SLOT_BITS'($urandom_range(0, 15));
    dst = FIELD_SLOT_BITS'($urandom_range(0, 15));
    // mostly transfers between live slots, the rest go astray
    if (op == OP_TRANSFER && $urandom_range(0, 9) < 8) begin
      src = random_live_slot();
      dst = random_live_slot();
    end
    case ($urandom_range(0, 5))
      0:       count = '0;
      1:       count = '1;
      2, 3:    count = COUNT_BITS'($urandom_range(1, 200));
      default: count = COUNT_BITS'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       draw = '0;
      1:       draw = '1;
      2:       draw = DRAW_BITS'($urandom_range(0, 1000));
      default: draw = DRAW_BITS'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       mask = '0;
      1:       mask = '1;
      2:       mask = ~(MASK_BITS'(1) << $urandom_range(0, 15));
      3:       mask = MASK_BITS'(1) << $urandom_range(0, 15);
      default: mask = MASK_BITS'($urandom);
    endcase
    offer_item(op, src, dst, count, draw, mask);
  endtask

  task automatic run_directed_items();
    // empty table: nothing to draw from, nothing to move, harmless release
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, 31'd0, 16'h0000);
    offer_item(OP_TRANSFER, 4'd1, 4'd2, 16'd5, 31'd0, 16'h0000);
    offer_item(OP_RELEASE, 4'd3, 4'd0, 16'd0, 31'd0, 16'h0000);
    // count extremes; slot 0 in use but holding nothing
    offer_item(OP_ASSIGN, 4'd0, 4'd0, 16'h0000, 31'd0, 16'h0000);
    offer_item(OP_ASSIGN, 4'd15, 4'd0, 16'hFFFF, 31'd0, 16'h0000);
    offer_item(OP_ASSIGN, 4'd5, 4'd0, 16'd1, 31'd0, 16'h0000);
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, 31'd0, 16'h0000);
    offer_item(OP_SCHEDULE, 4'd15, 4'd15, 16'hFFFF, '1, 16'h0000);
    // winner blocked: search wraps round to the empty slot 0
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, '1, 16'h8000);
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, '1, 16'h8001);
    // every slot blocked
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, 31'h12345, 16'hFFFF);
    // destination saturates, self transfer, empty source, short source
    offer_item(OP_TRANSFER, 4'd15, 4'd5, 16'hFFFF, 31'd0, 16'h0000);
    offer_item(OP_TRANSFER, 4'd5, 4'd5, 16'd100, 31'd0, 16'h0000);
    offer_item(OP_TRANSFER, 4'd0, 4'd5, 16'd10, 31'd0, 16'h0000);
    offer_item(OP_ASSIGN, 4'd7, 4'd0, 16'd30, 31'd0, 16'h0000);
    offer_item(OP_TRANSFER, 4'd7, 4'd0, 16'd50, 31'd0, 16'h0000);
    // source or destination not in use
    offer_item(OP_TRANSFER, 4'd3, 4'd5, 16'd1, 31'd0, 16'h0000);
    offer_item(OP_TRANSFER, 4'd5, 4'd3, 16'd1, 31'd0, 16'h0000);
    // overwrite a slot already in use
    offer_item(OP_ASSIGN, 4'd0, 4'd0, 16'd9, 31'd0, 16'h0000);
    offer_item(OP_ASSIGN, 4'd0, 4'd0, 16'd4, 31'd0, 16'h0000);
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, 31'd3, 16'h0000);
    // release the rest; zero total with a slot still in use
    offer_item(OP_RELEASE, 4'd15, 4'd0, 16'd0, 31'd0, 16'h0000);
    offer_item(OP_RELEASE, 4'd5, 4'd0, 16'd0, 31'd0, 16'h0000);
    offer_item(OP_RELEASE, 4'd7, 4'd0, 16'd0, 31'd0, 16'h0000);
    offer_item(OP_ASSIGN, 4'd0, 4'd0, 16'd0, 31'd0, 16'h0000);
    offer_item(OP_SCHEDULE, 4'd0, 4'd0, 16'd0, '1, 16'h0000);
  endtask

  // Sender: reset, directed items, random items, drain and verdict
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= '0;
    in_ch.slot         <= '0;
    in_ch.target_slot  <= '0;
    in_ch.ticket_count <= '0;
    in_ch.draw_value   <= '0;
    in_ch.blocked_mask <= '0;
    for (int i = 0; i < SLOT_COUNT; i++) shadow_live[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed_items();
    repeat (RANDOM_ITEMS) offer_random_item();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: phases of steady, random, sparse and periodic readiness
  initial begin
    int phase, mode, span, k, held;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    phase = 0;
    forever begin
      phase++;
      // one long hold-off while the sender keeps offering
      if (phase == HOLD_OFF_PHASE) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((k % 5) < 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
hdl/ls_pkg.sv
hdl/ls_in_if.sv
hdl/ls_out_if.sv
hdl/ls_ram.sv
hdl/ls_rem.sv
hdl/ls_ctrl.sv
hdl/lottery_scheduler_top.sv
test/lottery_result_checker.sv
test/lottery_scheduler_top_test.sv
